// ----- hdl/vwah_pkg.sv -----
package vwah_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SAMPLE_BITS_MAX = 16;

    localparam int VOLT_BITS     = 8;
    localparam int TH_BITS       = 10;
    localparam int HYST_BITS     = 7;
    localparam int ALARM_BITS    = 2;
    localparam int IDX_BITS      = 3;
    localparam int CFG_DATA_BITS = 10;

    // Scale factors: volts = sample * MUL / DIV, high range first
    localparam longint unsigned HI_MUL = 236;
    localparam longint unsigned HI_DIV = 5440;
    localparam longint unsigned LO_MUL = 120;
    localparam longint unsigned LO_DIV = 2676;
    localparam logic [VOLT_BITS-1:0] RANGE_SWITCH = VOLT_BITS'(150);

    // Reciprocal multiply, exact for every sample below 2**SAMPLE_BITS_MAX
    localparam int RECIP_SHIFT = SAMPLE_BITS_MAX + $clog2(HI_DIV);
    localparam longint unsigned HI_RECIP =
        ((HI_MUL << RECIP_SHIFT) + HI_DIV - 1) / HI_DIV;
    localparam longint unsigned LO_RECIP =
        ((LO_MUL << RECIP_SHIFT) + LO_DIV - 1) / LO_DIV;
    localparam int RECIP_BITS =
        $clog2(((HI_RECIP > LO_RECIP) ? HI_RECIP : LO_RECIP) + 1);

    localparam logic [ALARM_BITS-1:0] ALARM_NONE  = 2'd0;
    localparam logic [ALARM_BITS-1:0] ALARM_UNDER = 2'd1;
    localparam logic [ALARM_BITS-1:0] ALARM_OVER  = 2'd2;

    localparam logic [IDX_BITS-1:0] REG_UNDER_TH = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_OVER_TH  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_HYST     = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_UNDER_EN = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_OVER_EN  = 3'd4;

    localparam logic [TH_BITS-1:0] UNDER_TH_RST = TH_BITS'(0);
    localparam logic [TH_BITS-1:0] OVER_TH_RST  = TH_BITS'(999);

    typedef struct packed {
        logic [TH_BITS-1:0]   under_th;
        logic [TH_BITS-1:0]   over_th;
        logic [HYST_BITS-1:0] hyst;
        logic                 under_en;
        logic                 over_en;
    } t_cfg;

    // Both range candidates of one sample, already truncated to volts width
    typedef struct packed {
        logic [VOLT_BITS-1:0] hi_volts;
        logic [VOLT_BITS-1:0] lo_volts;
    } t_scaled;

endpackage

// ----- hdl/vwah_if.sv -----
interface vwah_sample_if #(
    parameter int SAMPLE_BITS = vwah_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface vwah_result_if;
    logic                                valid;
    logic                                ready;
    logic [vwah_pkg::VOLT_BITS-1:0]      volts;
    logic [vwah_pkg::ALARM_BITS-1:0]     alarm_code;
    logic                                release_pulse;

    modport source (output valid, output volts, output alarm_code, output release_pulse,
                    input ready);
    modport sink   (input valid, input volts, input alarm_code, input release_pulse,
                    output ready);
endinterface

interface vwah_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vwah_pkg::IDX_BITS-1:0]       index;
    logic [vwah_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/vwah_cfg.sv -----
module vwah_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [vwah_pkg::IDX_BITS-1:0]      i_index,
    input  logic [vwah_pkg::CFG_DATA_BITS-1:0] i_data,
    output logic                               o_ready,
    output vwah_pkg::t_cfg                     o_cfg
);

    vwah_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.under_th <= vwah_pkg::UNDER_TH_RST;
            r_cfg.over_th  <= vwah_pkg::OVER_TH_RST;
            r_cfg.hyst     <= '0;
            r_cfg.under_en <= 1'b0;
            r_cfg.over_en  <= 1'b0;
        end else if (i_valid) begin
            unique case (i_index)
                vwah_pkg::REG_UNDER_TH: r_cfg.under_th <= i_data[vwah_pkg::TH_BITS-1:0];
                vwah_pkg::REG_OVER_TH:  r_cfg.over_th  <= i_data[vwah_pkg::TH_BITS-1:0];
                vwah_pkg::REG_HYST:     r_cfg.hyst     <= i_data[vwah_pkg::HYST_BITS-1:0];
                vwah_pkg::REG_UNDER_EN: r_cfg.under_en <= i_data[0];
                vwah_pkg::REG_OVER_EN:  r_cfg.over_en  <= i_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/vwah_scale.sv -----
module vwah_scale #(
    parameter int SAMPLE_BITS = vwah_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_ready,
    output logic                   o_valid,
    output vwah_pkg::t_scaled      o_scaled,
    input  logic                   i_ready
);

    localparam int SHIFT = vwah_pkg::RECIP_SHIFT;
    localparam int VB    = vwah_pkg::VOLT_BITS;
    localparam int PW    = (SAMPLE_BITS + vwah_pkg::RECIP_BITS > SHIFT + VB) ?
                           SAMPLE_BITS + vwah_pkg::RECIP_BITS : SHIFT + VB;

    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic                   r_s2_valid;
    vwah_pkg::t_scaled      r_s2_scaled;

    logic                   s2_ready;
    logic                   s1_ready;
    logic [PW-1:0]          hi_prod;
    logic [PW-1:0]          lo_prod;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign hi_prod = PW'(r_s1_sample) * PW'(vwah_pkg::HI_RECIP);
    assign lo_prod = PW'(r_s1_sample) * PW'(vwah_pkg::LO_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_sample <= i_sample;
        end
        // keep only the integer quotient, truncated to volts width
        if (s2_ready && r_s1_valid) begin
            r_s2_scaled.hi_volts <= hi_prod[SHIFT+VB-1:SHIFT];
            r_s2_scaled.lo_volts <= lo_prod[SHIFT+VB-1:SHIFT];
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_scaled = r_s2_scaled;

endmodule

// ----- hdl/vwah_alarm.sv -----
module vwah_alarm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vwah_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    input  vwah_pkg::t_scaled                   i_scaled,
    output logic                                o_ready,
    output logic                                o_valid,
    output logic [vwah_pkg::VOLT_BITS-1:0]      o_volts,
    output logic [vwah_pkg::ALARM_BITS-1:0]     o_alarm_code,
    output logic                                o_release_pulse,
    input  logic                                i_ready
);

    localparam int TW = vwah_pkg::TH_BITS + 1;

    logic                               r_valid;
    logic [vwah_pkg::VOLT_BITS-1:0]     r_volts;
    logic                               r_pulse;
    logic [vwah_pkg::ALARM_BITS-1:0]    r_latch;

    logic                               load;
    logic [vwah_pkg::VOLT_BITS-1:0]     volts;
    logic [TW-1:0]                      volts_ext;
    logic [TW-1:0]                      under_rel_lim;
    logic [TW-1:0]                      over_rel_lim;
    logic [vwah_pkg::ALARM_BITS-1:0]    n_latch;
    logic                               n_pulse;

    assign o_ready = !r_valid || i_ready;
    assign load    = o_ready && i_valid;

    assign volts = (i_scaled.hi_volts < vwah_pkg::RANGE_SWITCH) ?
                   i_scaled.lo_volts : i_scaled.hi_volts;
    assign volts_ext     = TW'(volts);
    assign under_rel_lim = TW'(i_cfg.under_th) + TW'(i_cfg.hyst);
    assign over_rel_lim  = TW'(i_cfg.over_th) - TW'(i_cfg.hyst);

    always_comb begin
        n_latch = r_latch;
        n_pulse = 1'b0;
        if (i_cfg.under_en && (volts_ext < TW'(i_cfg.under_th))) begin
            n_latch = vwah_pkg::ALARM_UNDER;
        end
        if (i_cfg.over_en && (TW'(i_cfg.over_th) < volts_ext)) begin
            n_latch = vwah_pkg::ALARM_OVER;
        end
        if (!i_cfg.under_en && !i_cfg.over_en) begin
            n_latch = vwah_pkg::ALARM_NONE;
        end
        if (n_latch == vwah_pkg::ALARM_UNDER && i_cfg.under_en &&
            under_rel_lim < volts_ext) begin
            n_latch = vwah_pkg::ALARM_NONE;
            n_pulse = 1'b1;
        end
        // negative release limit never releases
        if (n_latch == vwah_pkg::ALARM_OVER && i_cfg.over_en &&
            $signed(volts_ext) < $signed(over_rel_lim)) begin
            n_latch = vwah_pkg::ALARM_NONE;
            n_pulse = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_latch <= vwah_pkg::ALARM_NONE;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_latch <= n_latch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_volts <= volts;
            r_pulse <= n_pulse;
        end
    end

    assign o_valid         = r_valid;
    assign o_volts         = r_volts;
    assign o_alarm_code    = r_latch;
    assign o_release_pulse = r_pulse;

endmodule

// ----- hdl/voltage_window_alarm_hysteresis.sv -----
// Channel       | Dir | Payload                              | Handshake
// i_sample_ch   | in  | sample[SAMPLE_BITS-1:0]              | valid/ready
// o_result_ch   | out | volts[7:0] alarm_code[1:0] release_pulse | valid/ready
// i_cfg_ch      | in  | index[2:0] data[9:0]                 | valid/ready, ready tied high
//
// One sample per cycle is taken unless a stalled result has backed up the pipeline; each
// sample passes in order through the stages: sample register, scale products (reciprocal
// multiply), alarm/result register.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the alarm latch and
// loads register defaults.
// A stalled result holds the result register; stages behind it keep filling until full.
module voltage_window_alarm_hysteresis #(
    parameter int SAMPLE_BITS = vwah_pkg::SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vwah_sample_if.sink   i_sample_ch,
    vwah_result_if.source o_result_ch,
    vwah_cfg_if.sink      i_cfg_ch
);

    vwah_pkg::t_cfg    cfg;
    vwah_pkg::t_scaled scaled;
    logic              scaled_valid;
    logic              scaled_ready;

    vwah_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_ch.valid),
        .i_index (i_cfg_ch.index),
        .i_data  (i_cfg_ch.data),
        .o_ready (i_cfg_ch.ready),
        .o_cfg   (cfg)
    );

    vwah_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sample_ch.valid),
        .i_sample (i_sample_ch.sample),
        .o_ready  (i_sample_ch.ready),
        .o_valid  (scaled_valid),
        .o_scaled (scaled),
        .i_ready  (scaled_ready)
    );

    vwah_alarm u_alarm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (scaled_valid),
        .i_scaled        (scaled),
        .o_ready         (scaled_ready),
        .o_valid         (o_result_ch.valid),
        .o_volts         (o_result_ch.volts),
        .o_alarm_code    (o_result_ch.alarm_code),
        .o_release_pulse (o_result_ch.release_pulse),
        .i_ready         (o_result_ch.ready)
    );

endmodule

// ----- hdl/vwah_chk.sv -----
module vwah_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [vwah_pkg::VOLT_BITS-1:0]  i_volts,
    input logic [vwah_pkg::ALARM_BITS-1:0] i_alarm_code,
    input logic                            i_release_pulse
);

    logic [vwah_pkg::ALARM_BITS-1:0] r_last_code;

    // track the alarm code of the last delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_code <= vwah_pkg::ALARM_NONE;
        end else if (i_out_valid && i_out_ready) begin
            r_last_code <= i_alarm_code;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_volts) && $stable(i_alarm_code) &&
            $stable(i_release_pulse))
        else $error("stalled result changed");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_release_pulse |-> i_alarm_code == vwah_pkg::ALARM_NONE)
        else $error("release with alarm still set");

    a_release_after_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_release_pulse |->
            r_last_code != vwah_pkg::ALARM_NONE)
        else $error("release without a prior alarm");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while output free");

endmodule

bind voltage_window_alarm_hysteresis vwah_chk u_vwah_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_sample_ch.ready),
    .i_out_valid     (o_result_ch.valid),
    .i_out_ready     (o_result_ch.ready),
    .i_volts         (o_result_ch.volts),
    .i_alarm_code    (o_result_ch.alarm_code),
    .i_release_pulse (o_result_ch.release_pulse)
);
